FILE: rtl/bf7z_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf7z_pkg
// Shared types and constants of the 7x7 zero-border box filter.
// ----------------------------------------------------------------------------
package bf7z_pkg;

    localparam int PIX_W       = 8;
    localparam int ROW_W       = 12;
    localparam int CFG_COLS_W  = 10;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 1;

    localparam int KSIZE       = 7;
    localparam int HIST        = 6;
    localparam int HALF        = 3;

    localparam int COLSUM_W    = 11;
    localparam int SUM_W       = 14;
    localparam int ROUND_ADD   = 24;
    localparam int RECIP       = 21400;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 15;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam int ROWS_MIN    = 7;
    localparam int COLS_MIN    = 7;
    localparam int ROWS_RESET  = 512;
    localparam int COLS_RESET  = 512;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_ROWS = 1'b0,
        REG_IMAGE_COLS = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic             border;
        logic             interior;
        logic [ROW_W-1:0] row;
    } item_tag_t;

endpackage

FILE: rtl/bf7z_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf7z_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bf7z_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bf7z_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf7z_cell
// One column of the 7x7 window, held as its column sum and shifted onward.
// ----------------------------------------------------------------------------
module bf7z_cell (
    input  logic                          aclk,
    input  logic                          shift_en,
    input  logic [bf7z_pkg::COLSUM_W-1:0] sum_in,
    output logic [bf7z_pkg::COLSUM_W-1:0] sum_out
);

    logic [bf7z_pkg::COLSUM_W-1:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            sum_reg <= sum_in;
        end
    end

    assign sum_out = sum_reg;

endmodule

FILE: rtl/box_filter_7x7_zero_border_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_7x7_zero_border_core
// Streaming 7x7 mean filter with a zero border on 8-bit greyscale pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the s_ channel, one beat per pixel. Each
// pixel yields a zero beat for its own position when that position lies in
// the three-pixel border, and, once six rows and six columns are in, the
// rounded mean of the window centered three rows and three columns back.
// Result beats leave on the m_ channel with their coordinates; the last
// beat caused by one pixel carries m_last_of_run.
// Frame size is set through cfg_we, cfg_index and cfg_data; the user must set
// it only while no pixel is in flight, as the block does not enforce this.
// The block takes one pixel per cycle unless m_ready stalls it; a pixel with
// two results holds the input until its first beat is taken, since the
// output moves one beat per cycle. Six rows of history live in one RAM of
// MAX_COLS words, read and written once per pixel; the window is a chain of
// seven column cells. Reset clears the counters and the pipeline and loads a
// 512x512 frame size; no clearing pass is needed. When a result beat waits on
// a low m_ready, the whole pipeline holds and s_ready drops.
// ----------------------------------------------------------------------------
module box_filter_7x7_zero_border_core #(
    parameter int MAX_COLS = 512
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_we,
    input  logic [bf7z_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bf7z_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bf7z_pkg::PIX_W-1:0]        s_pixel,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bf7z_pkg::ROW_W-1:0]        m_out_row,
    output logic [$clog2(MAX_COLS)-1:0]       m_out_col,
    output logic [bf7z_pkg::PIX_W-1:0]        m_smoothed_value,
    output logic                              m_last_of_run
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int WW    = (COL_W + 1 > bf7z_pkg::CFG_COLS_W) ? COL_W + 1
                                                              : bf7z_pkg::CFG_COLS_W;
    localparam int ROW_W = bf7z_pkg::ROW_W;
    localparam int PIX_W = bf7z_pkg::PIX_W;
    localparam int MEM_W = bf7z_pkg::HIST * PIX_W;
    localparam int CS_W  = bf7z_pkg::COLSUM_W;

    // Configuration registers.
    logic [ROW_W-1:0]                   image_rows_reg;
    logic [bf7z_pkg::CFG_COLS_W-1:0]    image_cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_rows_reg <= ROW_W'(bf7z_pkg::ROWS_RESET);
            image_cols_reg <= bf7z_pkg::CFG_COLS_W'(bf7z_pkg::COLS_RESET);
        end else if (cfg_we) begin
            case (bf7z_pkg::cfg_idx_t'(cfg_index))
                bf7z_pkg::REG_IMAGE_ROWS: image_rows_reg <= cfg_data;
                bf7z_pkg::REG_IMAGE_COLS:
                    image_cols_reg <= cfg_data[bf7z_pkg::CFG_COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size.
    logic [ROW_W-1:0] rows_eff;
    logic [WW-1:0]    cols_cfg;
    logic [WW-1:0]    cols_eff;

    assign rows_eff = (image_rows_reg < ROW_W'(bf7z_pkg::ROWS_MIN))
                    ? ROW_W'(bf7z_pkg::ROWS_MIN) : image_rows_reg;
    assign cols_cfg = WW'(image_cols_reg);
    assign cols_eff = (cols_cfg < WW'(bf7z_pkg::COLS_MIN)) ? WW'(bf7z_pkg::COLS_MIN)
                    : (cols_cfg > WW'(MAX_COLS)) ? WW'(MAX_COLS) : cols_cfg;

    // Pipeline control.
    logic adv;
    logic accept;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic second_reg;

    bf7z_pkg::item_tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [COL_W-1:0]    col1_reg, col2_reg, col3_reg, col4_reg;
    logic [PIX_W-1:0]    px1_reg;
    logic [bf7z_pkg::SUM_W-1:0]  total3_reg;
    logic [bf7z_pkg::PROD_W-1:0] prod4_reg;

    logic has_out4;
    logic show_border;
    logic final_beat;

    assign has_out4    = tag4_reg.border | tag4_reg.interior;
    assign show_border = tag4_reg.border & !second_reg;
    assign final_beat  = !(show_border & tag4_reg.interior);
    assign adv         = !v4_reg | !has_out4 | (m_ready & final_beat);
    assign accept      = s_valid & adv;
    assign s_ready     = adv;

    // Position counters and per-pixel flags.
    logic [ROW_W-1:0] row_cnt_reg;
    logic [COL_W-1:0] col_cnt_reg;
    logic [WW-1:0]    col_plus;
    logic [ROW_W:0]   row_plus;
    logic [ROW_W-1:0] row_cnt_next;
    logic [COL_W-1:0] col_cnt_next;
    bf7z_pkg::item_tag_t tag0;

    assign col_plus = WW'(col_cnt_reg) + WW'(1);
    assign row_plus = (ROW_W + 1)'(row_cnt_reg) + (ROW_W + 1)'(1);

    always_comb begin
        if (col_plus >= cols_eff) begin
            col_cnt_next = '0;
            row_cnt_next = (row_plus >= (ROW_W + 1)'(rows_eff)) ? '0 : row_plus[ROW_W-1:0];
        end else begin
            col_cnt_next = col_plus[COL_W-1:0];
            row_cnt_next = row_cnt_reg;
        end
    end

    assign tag0.row      = row_cnt_reg;
    assign tag0.border   = (row_cnt_reg < ROW_W'(bf7z_pkg::HALF))
                         | (row_cnt_reg >= rows_eff - ROW_W'(bf7z_pkg::HALF))
                         | (col_cnt_reg < COL_W'(bf7z_pkg::HALF))
                         | (WW'(col_cnt_reg) >= cols_eff - WW'(bf7z_pkg::HALF));
    assign tag0.interior = (row_cnt_reg >= ROW_W'(bf7z_pkg::HIST))
                         & (col_cnt_reg >= COL_W'(bf7z_pkg::HIST));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end else if (accept) begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

    // Line store: six rows of history per column.
    logic [MEM_W-1:0] hist_rdata;
    logic [MEM_W-1:0] hist_wdata;

    assign hist_wdata = {px1_reg, hist_rdata[MEM_W-1:PIX_W]};

    bf7z_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_COLS)
    ) u_line_store (
        .aclk  (aclk),
        .we    (adv & v1_reg),
        .waddr (col1_reg),
        .wdata (hist_wdata),
        .re    (accept),
        .raddr (col_cnt_reg),
        .rdata (hist_rdata)
    );

    // Column sum of the new window column.
    logic [CS_W-1:0] colsum1;

    always_comb begin
        colsum1 = CS_W'(px1_reg);
        for (int j = 0; j < bf7z_pkg::HIST; j++) begin
            colsum1 = colsum1 + CS_W'(hist_rdata[j*PIX_W +: PIX_W]);
        end
    end

    // Window: a chain of column cells, newest at the top.
    logic [CS_W-1:0] cell_sum [bf7z_pkg::KSIZE];

    for (genvar i = 0; i < bf7z_pkg::KSIZE; i++) begin : g_cell
        if (i == bf7z_pkg::KSIZE - 1) begin : g_head
            bf7z_cell u_cell (
                .aclk     (aclk),
                .shift_en (adv & v1_reg),
                .sum_in   (colsum1),
                .sum_out  (cell_sum[i])
            );
        end else begin : g_body
            bf7z_cell u_cell (
                .aclk     (aclk),
                .shift_en (adv & v1_reg),
                .sum_in   (cell_sum[i+1]),
                .sum_out  (cell_sum[i])
            );
        end
    end

    logic [bf7z_pkg::SUM_W-1:0] total2;

    always_comb begin
        total2 = bf7z_pkg::SUM_W'(bf7z_pkg::ROUND_ADD);
        for (int i = 0; i < bf7z_pkg::KSIZE; i++) begin
            total2 = total2 + bf7z_pkg::SUM_W'(cell_sum[i]);
        end
    end

    // Pipeline registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag1_reg   <= tag0;
            col1_reg   <= col_cnt_reg;
            px1_reg    <= s_pixel;
            tag2_reg   <= tag1_reg;
            col2_reg   <= col1_reg;
            tag3_reg   <= tag2_reg;
            col3_reg   <= col2_reg;
            total3_reg <= total2;
            tag4_reg   <= tag3_reg;
            col4_reg   <= col3_reg;
            prod4_reg  <= bf7z_pkg::PROD_W'(total3_reg)
                        * bf7z_pkg::PROD_W'(bf7z_pkg::RECIP);
        end
    end

    // Output beats: the border beat first, then the interior beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_reg <= 1'b0;
        end else if (adv) begin
            second_reg <= 1'b0;
        end else if (m_valid & m_ready) begin
            second_reg <= 1'b1;
        end
    end

    assign m_valid       = v4_reg & has_out4;
    assign m_last_of_run = final_beat;

    always_comb begin
        if (show_border) begin
            m_out_row        = tag4_reg.row;
            m_out_col        = col4_reg;
            m_smoothed_value = '0;
        end else begin
            m_out_row        = tag4_reg.row - ROW_W'(bf7z_pkg::HALF);
            m_out_col        = col4_reg - COL_W'(bf7z_pkg::HALF);
            m_smoothed_value = prod4_reg[bf7z_pkg::RECIP_SHIFT +: PIX_W];
        end
    end

endmodule

FILE: rtl/bf7z_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf7z_port_checker
// Port-level checks of the box filter, bound to the top level.
// ----------------------------------------------------------------------------
module bf7z_port_checker #(
    parameter int MAX_COLS = 512
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [bf7z_pkg::ROW_W-1:0]    m_out_row,
    input logic [$clog2(MAX_COLS)-1:0]   m_out_col,
    input logic [bf7z_pkg::PIX_W-1:0]    m_smoothed_value,
    input logic                          m_last_of_run
);

    localparam int COL_W = $clog2(MAX_COLS);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_row) && $stable(m_out_col)
            && $stable(m_smoothed_value) && $stable(m_last_of_run))
        else $error("result beat changed while stalled");

    // A stalled output stalls the input.
    a_stall_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input ready while output is stalled");

    // The first of two beats from one pixel is a border beat.
    a_first_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> m_smoothed_value == '0)
        else $error("first beat of a pair is not zero");

    // The second beat follows at once, three rows and columns back.
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid && m_last_of_run
            && (m_out_row == $past(m_out_row) - bf7z_pkg::ROW_W'(bf7z_pkg::HALF))
            && (m_out_col == $past(m_out_col) - COL_W'(bf7z_pkg::HALF)))
        else $error("interior beat does not follow its border beat");

endmodule

bind box_filter_7x7_zero_border_core bf7z_port_checker #(
    .MAX_COLS (MAX_COLS)
) u_bf7z_port_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_out_row        (m_out_row),
    .m_out_col        (m_out_col),
    .m_smoothed_value (m_smoothed_value),
    .m_last_of_run    (m_last_of_run)
);
